// ===== sv/ltkm_pkg.sv =====
// ----------------------------------------------------------------------------
// ltkm_pkg
// Shared widths, command codes, walk token and cell control types for the
// loser-tree k-way merge selector.
// ----------------------------------------------------------------------------
package ltkm_pkg;

   localparam int RUNS   = 8;
   localparam int LEVELS = $clog2(RUNS);
   localparam int RUN_W  = $clog2(RUNS);
   localparam int IDX_W  = RUN_W + 1;
   localparam int SLOTS  = RUNS / 2;
   localparam int POS_W  = LEVELS - 1;
   localparam int KEY_W  = 32;
   localparam int CMD_W  = 2;

   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [IDX_W-1:0]        idx_type;
   typedef logic [RUN_W-1:0]        run_type;
   typedef logic [POS_W-1:0]        pos_type;

   localparam key_type KEY_MAX  = key_type'(32'h7FFF_FFFF);
   localparam key_type KEY_MIN  = key_type'(32'h8000_0000);
   localparam idx_type SENTINEL = idx_type'(RUNS);

   localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_BUILD   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REPLACE = 2'd2;

   // One contender climbing the tree: its leaf index, key and node slot.
   typedef struct packed {
      logic    valid;
      logic    last;
      idx_type idx;
      key_type key;
      pos_type pos;
   } walk_token_type;

   // Broadcast to every cell: clear before a build, key update on a load.
   typedef struct packed {
      logic    clear;
      logic    load;
      run_type load_run;
      key_type load_key;
   } cell_ctrl_type;

   // Keep the sentinel strictly below every real key.
   function automatic key_type sat_key(input key_type k);
      key_type r;
      r = k;
      if (k == KEY_MIN) begin
         r = KEY_MIN + key_type'(1);
      end
      return r;
   endfunction

endpackage

// ===== sv/ltkm_cell.sv =====
// ----------------------------------------------------------------------------
// ltkm_cell
// One tree level: holds that level's loser entries, plays the incoming
// contender against the stored loser and hands the winner to the next level.
// ----------------------------------------------------------------------------
module ltkm_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  ltkm_pkg::cell_ctrl_type ctrl,
   input  ltkm_pkg::walk_token_type up_tok,
   output ltkm_pkg::walk_token_type down_tok
);
   import ltkm_pkg::*;

   idx_type        slot_idx_ff [SLOTS];
   key_type        slot_key_ff [SLOTS];
   walk_token_type tok_ff;
   walk_token_type tok_in;
   idx_type        other_idx;
   key_type        other_key;
   logic           swap;

   always_comb begin
      other_idx  = slot_idx_ff[up_tok.pos];
      other_key  = slot_key_ff[up_tok.pos];
      // strict compare: equal keys keep the stored loser in place
      swap       = up_tok.key > other_key;
      tok_in     = up_tok;
      tok_in.pos = up_tok.pos >> 1;
      if (swap) begin
         tok_in.idx = other_idx;
         tok_in.key = other_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
         for (int e = 0; e < SLOTS; e++) begin
            slot_idx_ff[e] <= SENTINEL;
            slot_key_ff[e] <= KEY_MIN;
         end
      end else begin
         tok_ff <= tok_in;
         if (ctrl.clear) begin
            for (int e = 0; e < SLOTS; e++) begin
               slot_idx_ff[e] <= SENTINEL;
               slot_key_ff[e] <= KEY_MIN;
            end
         end else begin
            if (up_tok.valid && swap) begin
               slot_idx_ff[up_tok.pos] <= up_tok.idx;
               slot_key_ff[up_tok.pos] <= up_tok.key;
            end
            // keep the stored key copies in step with the leaf store
            if (ctrl.load) begin
               for (int e = 0; e < SLOTS; e++) begin
                  if (slot_idx_ff[e] == {1'b0, ctrl.load_run}) begin
                     slot_key_ff[e] <= ctrl.load_key;
                  end
               end
            end
         end
      end
   end

   assign down_tok = tok_ff;

endmodule

// ===== sv/loser_tree_kway_merge_top.sv =====
// ----------------------------------------------------------------------------
// loser_tree_kway_merge_top
// Loser-tree selector for a k-way merge of sorted runs.
// ----------------------------------------------------------------------------
// Usage:
//   req channel takes one command item: load (run_index, key) stores the
//   head key of a run, build sets up the tree over all runs, replace gives
//   the next key of the run that won last. Keys equal to the most negative
//   value are saturated one step up. rsp channel carries one item per build
//   and per replace: winner_run, winner_key and merge_done (winner key is the
//   largest signed value, so every run is exhausted).
// Timing:
//   A load updates the leaf store and the cell key copies and leaves the
//   selector idle. A replace climbs one tree level per cycle through a chain
//   of log2(RUNS) cells; no new item is taken until its result is in the output register.
//   A build feeds one leaf per cycle, last run first; its result follows the
//   last leaf out of the root, and no new item is taken until that result is in
//   the output register.
//   A replace before any build, and an unknown command, is taken and dropped.
// Reset:
//   The tree holds the sentinel everywhere; leaf keys are undefined until
//   loaded. A stalled receiver holds the result in the output register while
//   new items are still taken; a second finished walk waits in the winner
//   register and holds the input off until the receiver takes the first.
// ----------------------------------------------------------------------------
module loser_tree_kway_merge_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [ltkm_pkg::CMD_W-1:0]     req_command,
   input  logic [ltkm_pkg::RUN_W-1:0]     req_run_index,
   input  logic signed [ltkm_pkg::KEY_W-1:0] req_key,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [ltkm_pkg::RUN_W-1:0]     rsp_winner_run,
   output logic signed [ltkm_pkg::KEY_W-1:0] rsp_winner_key,
   output logic                           rsp_merge_done
);
   import ltkm_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_DRAIN, ST_HOLD} state_type;

   state_type      state_ff, state_in;
   run_type        issue_cnt_ff, issue_cnt_in;
   idx_type        win_idx_ff, win_idx_in;
   key_type        win_key_ff, win_key_in;
   logic           rsp_valid_ff, rsp_valid_in;
   run_type        rsp_run_ff, rsp_run_in;
   key_type        rsp_key_ff, rsp_key_in;
   logic           rsp_done_ff, rsp_done_in;
   key_type        leaf_key_ff [RUNS];

   logic           req_accept;
   key_type        in_key;
   logic           is_load, is_build, is_repl;
   logic           rsp_free;
   cell_ctrl_type  ctrl;
   walk_token_type chain_tok [LEVELS+1];
   walk_token_type root_tok;

   // take commands only between walks; loads may pass a waiting result
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign in_key     = sat_key(req_key);
   assign is_load    = req_accept && (req_command == CMD_LOAD);
   assign is_build   = req_accept && (req_command == CMD_BUILD);
   // drop a replace while the winner still points at the sentinel
   assign is_repl    = req_accept && (req_command == CMD_REPLACE) && (win_idx_ff < SENTINEL);
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      ctrl.clear    = is_build;
      ctrl.load     = is_load;
      ctrl.load_run = req_run_index;
      ctrl.load_key = in_key;
   end

   // Feed the leaf end of the chain: a replace contender, or one leaf per
   // cycle during a build from the last run down to run 0.
   always_comb begin
      chain_tok[0] = '0;
      if (is_repl) begin
         chain_tok[0].valid = 1'b1;
         chain_tok[0].last  = 1'b1;
         chain_tok[0].idx   = win_idx_ff;
         chain_tok[0].key   = in_key;
         chain_tok[0].pos   = win_idx_ff[RUN_W-1:1];
      end else if (state_ff == ST_ISSUE) begin
         chain_tok[0].valid = 1'b1;
         chain_tok[0].last  = (issue_cnt_ff == '0);
         chain_tok[0].idx   = {1'b0, issue_cnt_ff};
         chain_tok[0].key   = leaf_key_ff[issue_cnt_ff];
         chain_tok[0].pos   = issue_cnt_ff[RUN_W-1:1];
      end
   end

   // cell 0 holds the level just above the leaves, the last cell the root
   for (genvar g = 0; g < LEVELS; g++) begin : g_cell
      ltkm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .up_tok   (chain_tok[g]),
         .down_tok (chain_tok[g+1])
      );
   end

   assign root_tok = chain_tok[LEVELS];

   // leaf store: written by load and replace, read by the build sequencer
   always_ff @(posedge clock) begin
      if (is_load) begin
         leaf_key_ff[req_run_index] <= in_key;
      end else if (is_repl) begin
         leaf_key_ff[win_idx_ff[RUN_W-1:0]] <= in_key;
      end
   end

   always_comb begin
      state_in     = state_ff;
      issue_cnt_in = issue_cnt_ff;
      win_idx_in   = win_idx_ff;
      win_key_in   = win_key_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_run_in   = rsp_run_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_done_in  = rsp_done_ff;

      // the winner register follows each root token; the last one of a walk names the overall winner
      if (root_tok.valid) begin
         win_idx_in = root_tok.idx;
         win_key_in = root_tok.key;
      end else if (is_load && (win_idx_ff == {1'b0, req_run_index})) begin
         win_key_in = in_key;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (is_build) begin
               state_in     = ST_ISSUE;
               issue_cnt_in = run_type'(RUNS - 1);
            end else if (is_repl) begin
               state_in = ST_DRAIN;
            end
         end
         ST_ISSUE: begin
            issue_cnt_in = issue_cnt_ff - run_type'(1);
            if (issue_cnt_ff == '0) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (root_tok.valid && root_tok.last) begin
               if (rsp_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_run_in   = root_tok.idx[RUN_W-1:0];
                  rsp_key_in   = root_tok.key;
                  rsp_done_in  = (root_tok.key == KEY_MAX);
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_run_in   = win_idx_ff[RUN_W-1:0];
               rsp_key_in   = win_key_ff;
               rsp_done_in  = (win_key_ff == KEY_MAX);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_cnt_ff <= '0;
         win_idx_ff   <= SENTINEL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_cnt_ff <= issue_cnt_in;
         win_idx_ff   <= win_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      win_key_ff  <= win_key_in;
      rsp_run_ff  <= rsp_run_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_winner_run = rsp_run_ff;
   assign rsp_winner_key = rsp_key_ff;
   assign rsp_merge_done = rsp_done_ff;

   // a build always starts its leaf sequence from the last run
   a_build_start : assert property (@(posedge clock) disable iff (reset)
      is_build |=> (state_ff == ST_ISSUE) && (issue_cnt_ff == run_type'(RUNS - 1)))
      else $error("build did not start issuing from the last run");

   // tokens only leave the root while a walk is in flight
   a_root_in_walk : assert property (@(posedge clock) disable iff (reset)
      root_tok.valid |-> (state_ff == ST_ISSUE) || (state_ff == ST_DRAIN))
      else $error("root token outside a walk");

   // a finished walk always names a real run, never the sentinel
   a_real_winner : assert property (@(posedge clock) disable iff (reset)
      (root_tok.valid && root_tok.last) |-> (root_tok.idx < SENTINEL))
      else $error("walk finished on the sentinel");

   // done flag agrees with the key it reports
   a_done_flag : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_merge_done == (rsp_winner_key == KEY_MAX)))
      else $error("merge_done does not match winner key");

endmodule
